@@ design/mchw_pkg.sv @@
// Package for the heartbeat watchdog: payload types, codes and chain request type.
`default_nettype none
package mchw_pkg;

	localparam int MAX_CLIENTS = 8;
	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

	localparam logic [15:0] CHECK_INTERVAL_RST = 16'd1000;
	localparam logic [19:0] TIMEOUT_RST = 20'd5000;

	typedef enum logic [1:0] {
		CMD_REGISTER  = 2'd0,
		CMD_HEARTBEAT = 2'd1,
		CMD_TICK      = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_e_t;

	typedef enum logic [0:0] {
		CFG_CHECK_INTERVAL = 1'd0,
		CFG_TIMEOUT        = 1'd1
	} cfg_e_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_REG   = 3'd1,
		OP_FULL  = 3'd2,
		OP_HB    = 3'd3,
		OP_CHECK = 3'd4
	} op_e_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_RUN  = 2'd1,
		S_HOLD = 2'd2
	} state_e_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] client_id;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic       check_done;
		logic       feed;
		logic       missed_event;
		logic       first_failed_valid;
		logic [2:0] first_failed_slot;
	} out_t;

	// request walking the cell row, accumulating its answer on the way
	typedef struct packed {
		op_e_t            op;
		logic [7:0]       id;
		logic [31:0]      now;
		logic [19:0]      timeout;
		logic [CNT_W-1:0] count;
		logic             hit;
		logic [IDX_W-1:0] hit_slot;
		logic             all_ok;
		logic             ff_valid;
		logic [IDX_W-1:0] ff_slot;
	} req_t;

	function automatic logic [2:0] slot3(input logic [IDX_W-1:0] v);
		return 3'(v);
	endfunction

endpackage
`default_nettype wire

@@ design/mchw_cell.sv @@
// One client slot of the watchdog table; acts on the passing request and hands it on.
`default_nettype none
module mchw_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [mchw_pkg::IDX_W-1:0]  idx,
	input  wire logic                        in_valid,
	input  wire mchw_pkg::req_t              in_req,
	output logic                             out_valid,
	output mchw_pkg::req_t                   out_req
);
	import mchw_pkg::*;

	logic [7:0]  id_q;
	logic [31:0] time_q;
	logic        alive_q;
	logic        valid_q;
	req_t        req_q;

	req_t        nxt;
	logic        wr_new;
	logic        wr_beat;
	logic        kill;
	logic        in_range;
	logic [31:0] elapsed;

	always_comb begin
		nxt = in_req;
		wr_new = 1'b0;
		wr_beat = 1'b0;
		kill = 1'b0;
		in_range = CNT_W'(idx) < in_req.count;
		elapsed = in_req.now - time_q;
		case (in_req.op)
			OP_REG: begin
				wr_new = CNT_W'(idx) == in_req.count;
			end
			OP_HB: begin
				if (in_range && !in_req.hit && id_q == in_req.id) begin
					wr_beat = 1'b1;
					nxt.hit = 1'b1;
					nxt.hit_slot = idx;
				end
			end
			OP_CHECK: begin
				if (in_range && elapsed > 32'(in_req.timeout)) begin
					nxt.all_ok = 1'b0;
					if (alive_q) begin
						kill = 1'b1;
						if (!in_req.ff_valid) begin
							nxt.ff_valid = 1'b1;
							nxt.ff_slot = idx;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
			if (in_valid && (wr_new || wr_beat)) begin
				alive_q <= 1'b1;
			end else if (in_valid && kill) begin
				alive_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			req_q <= nxt;
			if (wr_new) begin
				id_q <= in_req.id;
			end
			if (wr_new || wr_beat) begin
				time_q <= in_req.now;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_req = req_q;

endmodule
`default_nettype wire

@@ design/multi_client_heartbeat_watchdog_core.sv @@
// Top level of the multi-client heartbeat watchdog: command intake, cell row, result register.
//
//  channel   direction  handshake             payload
//  cmd       in         cmd_valid/cmd_stall   cmd (command, client_id)
//  rsp       out        rsp_valid/rsp_stall   rsp (status, slot, check results)
//  cfg       in         cfg_we                cfg_index, cfg_wdata
//
// A transaction passes one launch register, then the register of each cell of the slot
// row in turn, and then the result register that drives the rsp outputs.
// One transaction is in the row at a time; the next is taken once the result
// sits in the output register, even while rsp is still stalled. A result that
// finds rsp stalled waits in a hold register and cmd stalls until it moves on.
// Reset clears the clock, counters, count and alive flags; slot ids and beat
// times need no clearing.
`default_nettype none
module multi_client_heartbeat_watchdog_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire mchw_pkg::in_t   cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output mchw_pkg::out_t       rsp,
	input  wire logic            cfg_we,
	input  wire logic [0:0]      cfg_index,
	input  wire logic [19:0]     cfg_wdata
);
	import mchw_pkg::*;

	state_e_t         state_q;
	state_e_t         state_d;
	logic [15:0]      interval_q;
	logic [19:0]      timeout_q;
	logic [31:0]      now_q;
	logic [15:0]      icount_q;
	logic [CNT_W-1:0] count_q;
	logic             launch_valid_q;
	req_t             launch_req_q;
	logic             rsp_valid_q;
	out_t             rsp_q;
	out_t             hold_q;

	logic             accept;
	logic             full;
	logic [15:0]      icount_next;
	logic             do_check;
	req_t             lreq;
	out_t             res;
	logic             out_free;
	logic             load_out;
	logic             load_hold;
	logic             from_hold;

	logic             chain_valid [MAX_CLIENTS+1];
	req_t             chain_req   [MAX_CLIENTS+1];
	logic [MAX_CLIENTS:0] valid_vec;

	assign accept = cmd_valid && !cmd_stall;
	assign full = count_q >= CNT_W'(MAX_CLIENTS);
	assign icount_next = icount_q + 16'd1;
	assign do_check = (icount_next >= interval_q) || (interval_q == 16'd0);
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		lreq = '0;
		lreq.id = cmd.client_id;
		lreq.now = now_q;
		lreq.timeout = timeout_q;
		lreq.count = count_q;
		lreq.all_ok = 1'b1;
		case (cmd.command)
			CMD_REGISTER: lreq.op = full ? OP_FULL : OP_REG;
			CMD_HEARTBEAT: lreq.op = OP_HB;
			CMD_TICK: begin
				lreq.now = now_q + 32'd1;
				lreq.op = do_check ? OP_CHECK : OP_NOP;
			end
			default: lreq.op = OP_NOP;
		endcase
	end

	assign chain_valid[0] = launch_valid_q;
	assign chain_req[0] = launch_req_q;

	for (genvar k = 0; k < MAX_CLIENTS; k++) begin : g_cell
		mchw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(k)),
			.in_valid (chain_valid[k]),
			.in_req   (chain_req[k]),
			.out_valid(chain_valid[k+1]),
			.out_req  (chain_req[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_CLIENTS; k++) begin : g_vv
		assign valid_vec[k] = chain_valid[k];
	end

	always_comb begin
		req_t t;
		t = chain_req[MAX_CLIENTS];
		res = '0;
		case (t.op)
			OP_REG: begin
				res.status = ST_OK;
				res.slot = 3'(t.count);
			end
			OP_FULL: res.status = ST_FULL;
			OP_HB: begin
				res.status = t.hit ? ST_OK : ST_NOT_FOUND;
				res.slot = t.hit ? slot3(t.hit_slot) : 3'd0;
			end
			OP_CHECK: begin
				res.check_done = 1'b1;
				res.feed = t.all_ok;
				res.missed_event = !t.all_ok;
				res.first_failed_valid = t.ff_valid;
				res.first_failed_slot = t.ff_valid ? slot3(t.ff_slot) : 3'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_RUN;
			S_RUN: begin
				if (chain_valid[MAX_CLIENTS]) begin
					state_d = out_free ? S_IDLE : S_HOLD;
				end
			end
			S_HOLD: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = 1'b1;
		load_out = 1'b0;
		load_hold = 1'b0;
		from_hold = 1'b0;
		case (state_q)
			S_IDLE: cmd_stall = 1'b0;
			S_RUN: begin
				load_out = chain_valid[MAX_CLIENTS] && out_free;
				load_hold = chain_valid[MAX_CLIENTS] && !out_free;
			end
			S_HOLD: begin
				load_out = out_free;
				from_hold = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			interval_q <= CHECK_INTERVAL_RST;
			timeout_q <= TIMEOUT_RST;
			now_q <= '0;
			icount_q <= '0;
			count_q <= '0;
			launch_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			launch_valid_q <= accept;
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHECK_INTERVAL: interval_q <= cfg_wdata[15:0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (cmd.command == CMD_REGISTER && !full) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.command == CMD_TICK) begin
					now_q <= now_q + 32'd1;
					icount_q <= do_check ? 16'd0 : icount_next;
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_req_q <= lreq;
		end
		if (load_hold) begin
			hold_q <= res;
		end
		if (load_out) begin
			rsp_q <= from_hold ? hold_q : res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CLIENTS))
		else $error("client count beyond table size");

	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec))
		else $error("more than one transaction in the cell row");

	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[MAX_CLIENTS] |-> state_q == S_RUN)
		else $error("row result outside run state");

	a_accept_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> launch_valid_q && state_q == S_RUN)
		else $error("accepted transaction not launched");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> count_q == CNT_W'(MAX_CLIENTS))
		else $error("table full reported with free slots");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the heartbeat watchdog core: directed table, random traffic, response checker.
module tb;
	import mchw_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 950;
	localparam int PRESSURE_AT = 320;
	localparam int PRESSURE_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam out_t RSP_NONE = '0;

	typedef struct {
		bit          is_cfg;
		logic [15:0] every;
		logic [19:0] limit;
		in_t         item;
		bit          lit;
		out_t        want;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	in_t         cmd = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	out_t        rsp;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [19:0] cfg_wdata = '0;

	// supervisor state mirrored by the predictor
	logic [7:0]  slot_id [MAX_CLIENTS];
	logic [31:0] slot_beat [MAX_CLIENTS];
	logic        slot_alive [MAX_CLIENTS] = '{default: 1'b0};
	int unsigned used_slots = 0;
	logic [31:0] clock_ms = '0;
	logic [15:0] tick_run = '0;
	logic [15:0] check_every = CHECK_INTERVAL_RST;
	logic [19:0] timeout_ms = TIMEOUT_RST;

	out_t        due_rsp [$];
	row_t        plan [$];
	out_t        head_rsp;
	int          errors = 0;
	int          rsp_seen = 0;
	int          hold = 0;
	int          quiet_cycles = 0;
	logic        calm = 1'b0;

	multi_client_heartbeat_watchdog_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic out_t supervisor_answer(input in_t it);
		out_t        r;
		logic [31:0] age;
		bit          all_ok;
		bit          hit;
		int          k;
		r = '0;
		all_ok = 1'b1;
		hit = 1'b0;
		case (it.command)
			CMD_REGISTER: begin
				if (used_slots >= MAX_CLIENTS) begin
					r.status = ST_FULL;
				end else begin
					slot_id[used_slots] = it.client_id;
					slot_beat[used_slots] = clock_ms;
					slot_alive[used_slots] = 1'b1;
					r.status = ST_OK;
					r.slot = 3'(used_slots);
					used_slots++;
				end
			end
			CMD_HEARTBEAT: begin
				r.status = ST_NOT_FOUND;
				for (k = 0; k < used_slots && !hit; k++) begin
					if (slot_id[k] == it.client_id) begin
						slot_beat[k] = clock_ms;
						slot_alive[k] = 1'b1;
						r.status = ST_OK;
						r.slot = 3'(k);
						hit = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				clock_ms = clock_ms + 32'd1;
				tick_run = tick_run + 16'd1;
				if (tick_run >= check_every || check_every == 16'd0) begin
					tick_run = '0;
					for (k = 0; k < used_slots; k++) begin
						age = clock_ms - slot_beat[k];
						if (age > 32'(timeout_ms)) begin
							all_ok = 1'b0;
							if (slot_alive[k]) begin
								slot_alive[k] = 1'b0;
								if (!hit) begin
									hit = 1'b1;
									r.first_failed_slot = 3'(k);
								end
							end
						end
					end
					r.check_done = 1'b1;
					r.feed = all_ok;
					r.missed_event = !all_ok;
					r.first_failed_valid = hit;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [15:0] every, input logic [19:0] limit);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.every = every;
		r.limit = limit;
		return r;
	endfunction

	function automatic row_t lit_row(input logic [1:0] c, input logic [7:0] id,
			input out_t want);
		row_t r;
		r = '{default: '0};
		r.item.command = c;
		r.item.client_id = id;
		r.lit = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic row_t cmd_row(input logic [1:0] c, input logic [7:0] id);
		row_t r;
		r = lit_row(c, id, RSP_NONE);
		r.lit = 1'b0;
		return r;
	endfunction

	function automatic bit field_bad(input string f, input logic [3:0] want,
			input logic [3:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, f, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input in_t it, input bit lit, input out_t want);
		out_t pred;
		int   gap;
		if (!calm && $urandom_range(99) < 15) begin
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pred = supervisor_answer(it);
		due_rsp.push_back(lit ? want : pred);
	endtask

	task automatic program_regs(input logic [15:0] every, input logic [19:0] limit);
		cmd_valid <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHECK_INTERVAL;
		cfg_wdata <= 20'(every);
		@(posedge clk);
		check_every = every;
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= limit;
		@(posedge clk);
		timeout_ms = limit;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					$display("%0t unexpected transaction: expected none, actual %h", $time, rsp);
					errors++;
				end else begin
					head_rsp = due_rsp.pop_front();
					errors += field_bad("status", 4'(head_rsp.status), 4'(rsp.status));
					errors += field_bad("slot", 4'(head_rsp.slot), 4'(rsp.slot));
					errors += field_bad("check_done", 4'(head_rsp.check_done),
						4'(rsp.check_done));
					errors += field_bad("feed", 4'(head_rsp.feed), 4'(rsp.feed));
					errors += field_bad("missed_event", 4'(head_rsp.missed_event),
						4'(rsp.missed_event));
					errors += field_bad("first_failed_valid", 4'(head_rsp.first_failed_valid),
						4'(rsp.first_failed_valid));
					errors += field_bad("first_failed_slot", 4'(head_rsp.first_failed_slot),
						4'(rsp.first_failed_slot));
				end
				rsp_seen++;
				if (rsp_seen == PRESSURE_AT)
					hold = PRESSURE_CYCLES;
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 15);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid === 1'b1 && !rsp_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		in_t         it;
		int          r;
		int          pick;
		logic [15:0] every;
		logic [19:0] limit;

		plan.push_back(lit_row(CMD_HEARTBEAT, 8'h05, out_t'({ST_NOT_FOUND, 10'd0})));
		plan.push_back(lit_row(CMD_UNUSED, 8'hFF, RSP_NONE));
		plan.push_back(lit_row(CMD_TICK, 8'h00, RSP_NONE));
		plan.push_back(cfg_row(16'd0, 20'd5000));
		plan.push_back(lit_row(CMD_TICK, 8'h00, out_t'({ST_OK, 3'd0, 4'b1100, 3'd0})));
		plan.push_back(cfg_row(16'd1, 20'd0));
		plan.push_back(lit_row(CMD_REGISTER, 8'h00, out_t'({ST_OK, 3'd0, 7'd0})));
		plan.push_back(lit_row(CMD_REGISTER, 8'hFF, out_t'({ST_OK, 3'd1, 7'd0})));
		plan.push_back(lit_row(CMD_REGISTER, 8'hFF, out_t'({ST_OK, 3'd2, 7'd0})));
		plan.push_back(cmd_row(CMD_REGISTER, 8'h5A));
		plan.push_back(cmd_row(CMD_REGISTER, 8'hA5));
		plan.push_back(cmd_row(CMD_REGISTER, 8'h0F));
		plan.push_back(cmd_row(CMD_REGISTER, 8'hF0));
		plan.push_back(cmd_row(CMD_REGISTER, 8'h33));
		plan.push_back(lit_row(CMD_REGISTER, 8'h77, out_t'({ST_FULL, 10'd0})));
		plan.push_back(lit_row(CMD_HEARTBEAT, 8'hFF, out_t'({ST_OK, 3'd1, 7'd0})));
		plan.push_back(lit_row(CMD_HEARTBEAT, 8'h12, out_t'({ST_NOT_FOUND, 10'd0})));
		plan.push_back(cmd_row(CMD_TICK, 8'h00));
		plan.push_back(cmd_row(CMD_TICK, 8'hFF));
		plan.push_back(cmd_row(CMD_HEARTBEAT, 8'h00));
		plan.push_back(cmd_row(CMD_TICK, 8'h00));
		plan.push_back(cfg_row(16'hFFFF, 20'hFFFFF));
		plan.push_back(lit_row(CMD_TICK, 8'h00, RSP_NONE));
		plan.push_back(lit_row(CMD_TICK, 8'h00, RSP_NONE));
		plan.push_back(lit_row(CMD_TICK, 8'h00, RSP_NONE));
		plan.push_back(cfg_row(16'd2, 20'hFFFFF));
		plan.push_back(cmd_row(CMD_TICK, 8'h00));
		plan.push_back(lit_row(CMD_UNUSED, 8'h00, RSP_NONE));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				program_regs(plan[i].every, plan[i].limit);
			else
				send_item(plan[i].item, plan[i].lit, plan[i].want);
		end

		for (r = 0; r < RAND_ITEMS; r++) begin
			if (r == 400)
				calm <= 1'b1;
			if (r == 560)
				calm <= 1'b0;
			if (r % 100 == 50) begin
				case ($urandom_range(9))
					0: every = 16'd0;
					1: every = 16'hFFFF;
					2: every = 16'($urandom_range(7, 65535));
					default: every = 16'($urandom_range(1, 6));
				endcase
				case ($urandom_range(9))
					0: limit = 20'd0;
					1: limit = 20'hFFFFF;
					default: limit = 20'($urandom_range(0, 30));
				endcase
				program_regs(every, limit);
			end
			pick = $urandom_range(99);
			if (used_slots > 0 && $urandom_range(3) != 0)
				it.client_id = slot_id[$urandom_range(used_slots - 1)];
			else
				it.client_id = 8'($urandom_range(255));
			if (pick < 8)
				it.command = CMD_REGISTER;
			else if (pick < 11)
				it.command = CMD_UNUSED;
			else if (pick < 45)
				it.command = CMD_HEARTBEAT;
			else
				it.command = CMD_TICK;
			send_item(it, 1'b0, RSP_NONE);
		end

		cmd_valid <= 1'b0;
		while (due_rsp.size() != 0) @(posedge clk);
		repeat (3 * (MAX_CLIENTS + 2)) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
